[design/max_heap_priority_queue_top_macros.svh]
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef MAX_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MHPQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("heap queue check failed");

// Next-cycle implication, disabled during reset.
`define MHPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("heap queue check failed");

`endif

[design/mhpq_pkg.sv]
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared sizes, codes and controller/datapath interface types for the
// max-heap priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mhpq_pkg;

  localparam int DATA_W = 32;
  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ST_W   = 2;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  // operation codes
  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // memory read position select
  localparam int RD_W = 3;
  localparam logic [RD_W-1:0] RD_ROOT   = 3'd0;
  localparam logic [RD_W-1:0] RD_LAST   = 3'd1;
  localparam logic [RD_W-1:0] RD_PARENT = 3'd2;
  localparam logic [RD_W-1:0] RD_LEFT   = 3'd3;
  localparam logic [RD_W-1:0] RD_RIGHT  = 3'd4;

  // memory write data select (address is always the current node)
  localparam int WR_W = 2;
  localparam logic [WR_W-1:0] WR_PARENT = 2'd0;
  localparam logic [WR_W-1:0] WR_CVAL   = 2'd1;
  localparam logic [WR_W-1:0] WR_VAL    = 2'd2;

  typedef struct packed {
    logic            load_in;
    logic            ins_start;
    logic            dn_start;
    logic            rd_en;
    logic [RD_W-1:0] rd_sel;
    logic            wr_en;
    logic [WR_W-1:0] wr_sel;
    logic            node_up;
    logic            node_down;
    logic            cap_top;
    logic            cap_val;
    logic            child_left;
    logic            cap_cval;
    logic            take_right;
    logic            set_st;
    logic [ST_W-1:0] st_code;
    logic            load_out;
  } ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic node_gt1;
    logic has_left;
    logic has_right;
    logic up_less;
    logic right_gt;
    logic down_less;
    logic count_nz;
  } stat_t;

endpackage

[design/max_heap_priority_queue_top.sv]
// ----------------------------------------------------------------------------
// max_heap_priority_queue_top
// Priority queue of signed 32-bit values kept as a binary max-heap in a
// 1024-entry single-port-write, registered-read memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, cmd, value): cmd 0 inserts value,
//   cmd 1 extracts the maximum. One transaction is taken at a time.
//   Output channel (out_valid/out_ready, top_value, status, entries): one
//   result per input transaction, in order. status 0 ok, 1 empty on
//   extract, 2 full on insert; top_value is the maximum on a good extract,
//   else zero; entries is the count after the operation.
// Operation: insert climbs from the new last position while the parent is
//   smaller; extract moves the last entry to the root and sinks it below
//   any larger child. Full/empty rejects touch no memory.
// Pacing: a transaction is not taken while the previous one is in
//   progress; the next one is taken the cycle after a result is loaded.
// Each heap level costs one or two registered reads and a write.
// Reset: rst empties the queue and holds in_ready low; memory
//   contents are not cleared.
// Stall: a result waits in the output register while the next transaction
//   is processed; the block holds only when a second result is ready first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module max_heap_priority_queue_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               cmd,
  input  logic signed [mhpq_pkg::DATA_W-1:0] value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [mhpq_pkg::DATA_W-1:0] top_value,
  output logic [mhpq_pkg::ST_W-1:0]          status,
  output logic [mhpq_pkg::CNT_W-1:0]         entries
);

  mhpq_pkg::ctl_t  ctl;
  mhpq_pkg::stat_t st;

  mhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .ctl       (ctl)
  );

  mhpq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .value     (value),
    .st        (st),
    .top_value (top_value),
    .status    (status),
    .entries   (entries)
  );

endmodule

[design/mhpq_dp.sv]
// ----------------------------------------------------------------------------
// mhpq_dp
// Heap datapath: value memory with registered read, entry count, node and
// child position registers, moving value, child value and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mhpq_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  mhpq_pkg::ctl_t                     ctl,
  input  logic signed [mhpq_pkg::DATA_W-1:0] value,
  output mhpq_pkg::stat_t                    st,
  output logic signed [mhpq_pkg::DATA_W-1:0] top_value,
  output logic [mhpq_pkg::ST_W-1:0]          status,
  output logic [mhpq_pkg::CNT_W-1:0]         entries
);

  logic signed [mhpq_pkg::DATA_W-1:0] mem [mhpq_pkg::DEPTH];

  logic [mhpq_pkg::CNT_W-1:0]         count;
  logic [mhpq_pkg::CNT_W-1:0]         node;
  logic [mhpq_pkg::CNT_W-1:0]         child;
  logic signed [mhpq_pkg::DATA_W-1:0] val;
  logic signed [mhpq_pkg::DATA_W-1:0] cval;
  logic signed [mhpq_pkg::DATA_W-1:0] top;
  logic signed [mhpq_pkg::DATA_W-1:0] rdata;
  logic [mhpq_pkg::ST_W-1:0]          st_code;

  logic [mhpq_pkg::CNT_W:0]           left_pos;
  logic [mhpq_pkg::CNT_W-1:0]         rd_pos;
  logic [mhpq_pkg::CNT_W-1:0]         rd_pos_m1;
  logic [mhpq_pkg::CNT_W-1:0]         wr_pos_m1;
  logic [mhpq_pkg::ADDR_W-1:0]        raddr;
  logic [mhpq_pkg::ADDR_W-1:0]        waddr;
  logic signed [mhpq_pkg::DATA_W-1:0] wdata;

  assign left_pos = {node, 1'b0};

  always_comb begin
    case (ctl.rd_sel)
      mhpq_pkg::RD_ROOT:   rd_pos = mhpq_pkg::CNT_W'(1);
      mhpq_pkg::RD_LAST:   rd_pos = count;
      mhpq_pkg::RD_PARENT: rd_pos = node >> 1;
      mhpq_pkg::RD_LEFT:   rd_pos = left_pos[mhpq_pkg::CNT_W-1:0];
      mhpq_pkg::RD_RIGHT:  rd_pos = child + mhpq_pkg::CNT_W'(1);
      default:             rd_pos = mhpq_pkg::CNT_W'(1);
    endcase
  end

  // positions are one-based, the memory is zero-based
  assign rd_pos_m1 = rd_pos - mhpq_pkg::CNT_W'(1);
  assign wr_pos_m1 = node - mhpq_pkg::CNT_W'(1);
  assign raddr     = rd_pos_m1[mhpq_pkg::ADDR_W-1:0];
  assign waddr     = wr_pos_m1[mhpq_pkg::ADDR_W-1:0];

  always_comb begin
    case (ctl.wr_sel)
      mhpq_pkg::WR_PARENT: wdata = rdata;
      mhpq_pkg::WR_CVAL:   wdata = cval;
      mhpq_pkg::WR_VAL:    wdata = val;
      default:             wdata = val;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.ins_start) begin
      count <= count + mhpq_pkg::CNT_W'(1);
    end else if (ctl.dn_start) begin
      count <= count - mhpq_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins_start) begin
      node <= count + mhpq_pkg::CNT_W'(1);
    end else if (ctl.dn_start) begin
      node <= mhpq_pkg::CNT_W'(1);
    end else if (ctl.node_up) begin
      node <= node >> 1;
    end else if (ctl.node_down) begin
      node <= child;
    end

    if (ctl.child_left) begin
      child <= left_pos[mhpq_pkg::CNT_W-1:0];
    end else if (ctl.take_right) begin
      child <= child + mhpq_pkg::CNT_W'(1);
    end

    if (ctl.cap_cval || ctl.take_right) begin
      cval <= rdata;
    end

    if (ctl.load_in) begin
      val <= value;
    end else if (ctl.cap_val) begin
      val <= rdata;
    end

    if (ctl.load_in) begin
      top <= '0;
    end else if (ctl.cap_top) begin
      top <= rdata;
    end

    if (ctl.set_st) begin
      st_code <= ctl.st_code;
    end

    if (ctl.load_out) begin
      top_value <= top;
      status    <= st_code;
      entries   <= count;
    end
  end

  always_comb begin
    st.full      = (count == mhpq_pkg::DEPTH_CNT);
    st.empty     = (count == '0);
    st.node_gt1  = (node > mhpq_pkg::CNT_W'(1));
    st.has_left  = (left_pos <= {1'b0, count});
    st.has_right = (child != count);
    st.up_less   = (rdata < val);
    st.right_gt  = (cval < rdata);
    st.down_less = (val < cval);
    st.count_nz  = (count != '0);
  end

endmodule

[design/mhpq_ctrl.sv]
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Sequencer for insert (sift-up) and extract (sift-down), plus the
// handshakes of both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mhpq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            cmd,
  output logic            out_valid,
  input  logic            out_ready,
  input  mhpq_pkg::stat_t st,
  output mhpq_pkg::ctl_t  ctl
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_UP_RD  = 4'd1;
  localparam logic [3:0] S_UP_CMP = 4'd2;
  localparam logic [3:0] S_DN_TOP = 4'd3;
  localparam logic [3:0] S_DN_VAL = 4'd4;
  localparam logic [3:0] S_DN_CHK = 4'd5;
  localparam logic [3:0] S_DN_L   = 4'd6;
  localparam logic [3:0] S_DN_R   = 4'd7;
  localparam logic [3:0] S_DN_CMP = 4'd8;
  localparam logic [3:0] S_FINAL  = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_valid_next;

  // nothing is taken while reset is held
  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load_in = 1'b1;
          ctl.set_st  = 1'b1;
          if (cmd == mhpq_pkg::CMD_INSERT) begin
            if (st.full) begin
              ctl.st_code = mhpq_pkg::ST_FULL;
              state_next  = S_DONE;
            end else begin
              ctl.st_code   = mhpq_pkg::ST_OK;
              ctl.ins_start = 1'b1;
              state_next    = S_UP_RD;
            end
          end else begin
            if (st.empty) begin
              ctl.st_code = mhpq_pkg::ST_EMPTY;
              state_next  = S_DONE;
            end else begin
              ctl.st_code = mhpq_pkg::ST_OK;
              ctl.rd_en   = 1'b1;
              ctl.rd_sel  = mhpq_pkg::RD_ROOT;
              state_next  = S_DN_TOP;
            end
          end
        end
      end
      S_UP_RD: begin
        if (st.node_gt1) begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = mhpq_pkg::RD_PARENT;
          state_next = S_UP_CMP;
        end else begin
          ctl.wr_en  = 1'b1;
          ctl.wr_sel = mhpq_pkg::WR_VAL;
          state_next = S_DONE;
        end
      end
      S_UP_CMP: begin
        ctl.wr_en = 1'b1;
        if (st.up_less) begin
          // parent moves down one level, keep climbing
          ctl.wr_sel  = mhpq_pkg::WR_PARENT;
          ctl.node_up = 1'b1;
          state_next  = S_UP_RD;
        end else begin
          ctl.wr_sel = mhpq_pkg::WR_VAL;
          state_next = S_DONE;
        end
      end
      S_DN_TOP: begin
        // root data arrives; fetch the last entry before the count drops
        ctl.cap_top  = 1'b1;
        ctl.rd_en    = 1'b1;
        ctl.rd_sel   = mhpq_pkg::RD_LAST;
        ctl.dn_start = 1'b1;
        state_next   = S_DN_VAL;
      end
      S_DN_VAL: begin
        ctl.cap_val = 1'b1;
        state_next  = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (st.has_left) begin
          ctl.rd_en      = 1'b1;
          ctl.rd_sel     = mhpq_pkg::RD_LEFT;
          ctl.child_left = 1'b1;
          state_next     = S_DN_L;
        end else begin
          state_next = S_FINAL;
        end
      end
      S_DN_L: begin
        ctl.cap_cval = 1'b1;
        if (st.has_right) begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = mhpq_pkg::RD_RIGHT;
          state_next = S_DN_R;
        end else begin
          state_next = S_DN_CMP;
        end
      end
      S_DN_R: begin
        ctl.take_right = st.right_gt;
        state_next     = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (st.down_less) begin
          ctl.wr_en     = 1'b1;
          ctl.wr_sel    = mhpq_pkg::WR_CVAL;
          ctl.node_down = 1'b1;
          state_next    = S_DN_CHK;
        end else begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        ctl.wr_en  = st.count_nz;
        ctl.wr_sel = mhpq_pkg::WR_VAL;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (ctl.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[design/mhpq_checker.sv]
// ----------------------------------------------------------------------------
// mhpq_checker
// Port-level checks on the priority queue results, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "max_heap_priority_queue_top_macros.svh"

module mhpq_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [mhpq_pkg::DATA_W-1:0] top_value,
  input logic [mhpq_pkg::ST_W-1:0]          status,
  input logic [mhpq_pkg::CNT_W-1:0]         entries
);

  logic [mhpq_pkg::DATA_W+mhpq_pkg::ST_W+mhpq_pkg::CNT_W-1:0] res_bus;
  logic                                                       rej_empty;
  logic                                                       rej_full;

  assign res_bus   = {top_value, status, entries};
  assign rej_empty = out_valid && (status == mhpq_pkg::ST_EMPTY);
  assign rej_full  = out_valid && (status == mhpq_pkg::ST_FULL);

  // a stalled result holds
  `MHPQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(res_bus))

  // an empty reject reports an empty queue and no value
  `MHPQ_ASSERT_NOW(a_empty_res, rej_empty, entries == '0 && top_value == '0)

  // a full reject reports a full queue and no value
  `MHPQ_ASSERT_NOW(a_full_res, rej_full, entries == mhpq_pkg::DEPTH_CNT && top_value == '0)

  // the count never exceeds capacity
  `MHPQ_ASSERT_NOW(a_count_cap, out_valid, entries <= mhpq_pkg::DEPTH_CNT)

  // one transaction at a time: ready drops after an accept
  `MHPQ_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

endmodule

bind max_heap_priority_queue_top mhpq_checker u_mhpq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .top_value (top_value),
  .status    (status),
  .entries   (entries)
);
